// ===== rtl/icit_pkg.sv =====
// shared types, constants and the control program of the cube test sequencer
`default_nettype none

package icit_pkg;

  localparam int GRID_DEPTH_DEF   = 4096;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int ISO_W            = 16;
  localparam int AXIS_W           = 13;
  localparam int XY_W             = 2 * AXIS_W;
  localparam int CFG_IDX_W        = 2;
  localparam int STEP_W           = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ISO_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_X    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Y    = 2'd2;

  localparam logic [AXIS_W-1:0] AXIS_RESET = 13'd2;

  localparam logic [STEP_W-1:0] ST_WAIT  = 4'd0;
  localparam logic [STEP_W-1:0] ST_PLANE = 4'd1;
  localparam logic [STEP_W-1:0] ST_FAR   = 4'd2;
  localparam logic [STEP_W-1:0] ST_CHECK = 4'd3;
  localparam logic [STEP_W-1:0] ST_C1    = 4'd4;
  localparam logic [STEP_W-1:0] ST_C2    = 4'd5;
  localparam logic [STEP_W-1:0] ST_C3    = 4'd6;
  localparam logic [STEP_W-1:0] ST_C4    = 4'd7;
  localparam logic [STEP_W-1:0] ST_C5    = 4'd8;
  localparam logic [STEP_W-1:0] ST_C6    = 4'd9;
  localparam logic [STEP_W-1:0] ST_C7    = 4'd10;
  localparam logic [STEP_W-1:0] ST_DRAIN = 4'd11;
  localparam logic [STEP_W-1:0] ST_EMIT  = 4'd12;
  localparam logic [STEP_W-1:0] ST_OOR   = 4'd13;

  typedef enum logic {A_BASE, A_ADDR} a_sel_t;
  typedef enum logic [1:0] {B_ZERO, B_X, B_XY} b_sel_t;
  typedef enum logic [1:0] {J_NEXT, J_IDLE, J_OOR, J_EMIT} jmp_t;

  typedef struct packed {
    logic              take;
    a_sel_t            a_sel;
    b_sel_t            b_sel;
    logic              cin;
    logic              ld_addr;
    logic              rd;
    logic              fold;
    logic              fold_init;
    logic              emit;
    logic              oor;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic query_acc;
    logic far_oor;
    logic out_free;
  } stat_t;

  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '0;
    case (step)
      ST_WAIT: begin
        w.take = 1'b1; w.jmp = J_IDLE; w.target = ST_WAIT;
      end
      ST_PLANE: begin
        w.ld_addr = 1'b1; w.a_sel = A_BASE; w.b_sel = B_XY;
      end
      ST_FAR: begin
        w.ld_addr = 1'b1; w.a_sel = A_ADDR; w.b_sel = B_X; w.cin = 1'b1;
      end
      ST_CHECK: begin
        w.ld_addr = 1'b1; w.a_sel = A_BASE; w.b_sel = B_ZERO;
        w.jmp = J_OOR; w.target = ST_OOR;
      end
      ST_C1: begin
        w.rd = 1'b1; w.ld_addr = 1'b1; w.a_sel = A_ADDR; w.cin = 1'b1;
      end
      ST_C2: begin
        w.rd = 1'b1; w.fold = 1'b1; w.fold_init = 1'b1;
        w.ld_addr = 1'b1; w.a_sel = A_BASE; w.b_sel = B_X;
      end
      ST_C3: begin
        w.rd = 1'b1; w.fold = 1'b1; w.ld_addr = 1'b1; w.a_sel = A_ADDR; w.cin = 1'b1;
      end
      ST_C4: begin
        w.rd = 1'b1; w.fold = 1'b1; w.ld_addr = 1'b1; w.a_sel = A_BASE; w.b_sel = B_XY;
      end
      ST_C5: begin
        w.rd = 1'b1; w.fold = 1'b1; w.ld_addr = 1'b1; w.a_sel = A_ADDR; w.b_sel = B_X;
      end
      ST_C6: begin
        w.rd = 1'b1; w.fold = 1'b1; w.ld_addr = 1'b1; w.a_sel = A_ADDR; w.cin = 1'b1;
      end
      ST_C7: begin
        w.rd = 1'b1; w.fold = 1'b1; w.ld_addr = 1'b1;
        w.a_sel = A_BASE; w.b_sel = B_XY; w.cin = 1'b1;
      end
      ST_DRAIN: begin
        w.rd = 1'b1; w.fold = 1'b1;
      end
      ST_EMIT: begin
        w.fold = 1'b1; w.emit = 1'b1; w.jmp = J_EMIT; w.target = ST_WAIT;
      end
      ST_OOR: begin
        w.emit = 1'b1; w.oor = 1'b1; w.jmp = J_EMIT; w.target = ST_WAIT;
      end
      default: begin
        w.jmp = J_EMIT; w.target = ST_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/iso_cube_intersection_test.sv =====
// top level: active-cube test over a volume of samples
//
// input words carry a kind bit, a linear vertex index and a sample value.
// a write word (kind 0) stores the sample at the vertex and gives no result;
// it does not stall the input, so writes stream at one word per cycle.
// a query word (kind 1) reads the eight corners of the cube based at the
// vertex, one corner per cycle from the single port of the sample memory,
// and returns the corner min, max and whether iso_level lies in [min, max).
// a query stalls the input while the sequencer runs its plane, far, check,
// corner, drain and emit steps; the result word is loaded in the emit step.
// a query whose farthest corner is beyond the store skips the corner reads
// and returns out_of_range through the out-of-range step.
// the result sits in an output register; the next input word is taken while
// it waits. if the receiver stalls and a second result is ready, the
// sequencer holds on that step until the register frees.
// configuration is a plain write port (iso_level, axis_x, axis_y), written
// while idle. synchronous reset sets iso_level to 0 and both axes to 2 and
// clears all control state; the sample memory is not cleared.
`default_nettype none

module iso_cube_intersection_test
  import icit_pkg::*;
#(
  parameter int GRID_DEPTH   = GRID_DEPTH_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [CFG_IDX_W-1:0]           cfg_index,
  input  wire logic [ISO_W-1:0]               cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_kind,
  input  wire logic [$clog2(GRID_DEPTH)-1:0]  in_vertex_index,
  input  wire logic [SAMPLE_WIDTH-1:0]        in_sample_value,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_intersected,
  output logic signed [SAMPLE_WIDTH-1:0]      out_cube_min,
  output logic signed [SAMPLE_WIDTH-1:0]      out_cube_max,
  output logic                                out_out_of_range
);

  uword_t uw;
  stat_t  st;
  logic   in_acc;

  assign in_stall = !uw.take;
  assign in_acc   = in_valid && uw.take;

  icit_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .uw    (uw)
  );

  icit_dpath #(
    .GRID_DEPTH   (GRID_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_acc           (in_acc),
    .in_kind          (in_kind),
    .in_vertex_index  (in_vertex_index),
    .in_sample_value  (in_sample_value),
    .uw               (uw),
    .st               (st),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_intersected  (out_intersected),
    .out_cube_min     (out_cube_min),
    .out_cube_max     (out_cube_max),
    .out_out_of_range (out_out_of_range)
  );

  a_query_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && !in_stall && in_kind |=> in_stall)
    else $error("query accept did not stall the input");

  a_write_keeps_input: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && !in_stall && !in_kind |=> !in_stall)
    else $error("write word blocked the next input word");

  a_oor_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> !out_intersected && out_cube_min == '0
      && out_cube_max == '0)
    else $error("out-of-range result carries data");

  a_hit_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_intersected |-> out_cube_min < out_cube_max)
    else $error("hit reported on a flat or inverted cube");

endmodule

`default_nettype wire

// ===== rtl/icit_ram.sv =====
// generic single-port RAM with registered read
`default_nettype none

module icit_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wr_data;
      end else begin
        rd_data_r <= mem_r[addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/icit_useq.sv =====
// step counter and control store of the cube test sequencer
`default_nettype none

module icit_useq
  import icit_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire stat_t  st,
  output uword_t      uw
);

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic [STEP_W-1:0] step_inc;

  assign uw       = ucode(step_r);
  assign step_inc = step_r + STEP_W'(1);

  always_comb begin
    case (uw.jmp)
      J_NEXT:  step_nxt = step_inc;
      J_IDLE:  step_nxt = st.query_acc ? step_inc : uw.target;
      J_OOR:   step_nxt = st.far_oor ? uw.target : step_inc;
      J_EMIT:  step_nxt = st.out_free ? uw.target : step_r;
      default: step_nxt = ST_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/icit_dpath.sv =====
// datapath: config registers, address adder, sample store, min/max fold, result word
`default_nettype none

module icit_dpath
  import icit_pkg::*;
#(
  parameter int GRID_DEPTH   = GRID_DEPTH_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [CFG_IDX_W-1:0]            cfg_index,
  input  wire logic [ISO_W-1:0]                cfg_wdata,
  input  wire logic                            in_acc,
  input  wire logic                            in_kind,
  input  wire logic [$clog2(GRID_DEPTH)-1:0]   in_vertex_index,
  input  wire logic [SAMPLE_WIDTH-1:0]         in_sample_value,
  input  wire uword_t                          uw,
  output stat_t                                st,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_intersected,
  output logic signed [SAMPLE_WIDTH-1:0]       out_cube_min,
  output logic signed [SAMPLE_WIDTH-1:0]       out_cube_max,
  output logic                                 out_out_of_range
);

  localparam int AW = $clog2(GRID_DEPTH);
  localparam int PW = ((AW > XY_W) ? AW : XY_W) + 2;
  localparam int CW = (SAMPLE_WIDTH > ISO_W) ? SAMPLE_WIDTH : ISO_W;

  logic signed [ISO_W-1:0]        iso_level_r;
  logic [AXIS_W-1:0]              axis_x_r;
  logic [AXIS_W-1:0]              axis_y_r;
  logic [XY_W-1:0]                xy_r;
  logic [PW-1:0]                  base_r;
  logic [PW-1:0]                  addr_r;
  logic [PW-1:0]                  a_op;
  logic [PW-1:0]                  b_op;
  logic [PW-1:0]                  sum;
  logic signed [SAMPLE_WIDTH-1:0] min_r;
  logic signed [SAMPLE_WIDTH-1:0] max_r;
  logic signed [SAMPLE_WIDTH-1:0] rd_data;
  logic signed [SAMPLE_WIDTH-1:0] fmin;
  logic signed [SAMPLE_WIDTH-1:0] fmax;
  logic signed [CW-1:0]           iso_ext;
  logic signed [CW-1:0]           fmin_ext;
  logic signed [CW-1:0]           fmax_ext;
  logic                           wr_en;
  logic                           ram_en;
  logic [AW-1:0]                  ram_addr;
  logic                           out_valid_r;
  logic                           out_intersected_r;
  logic signed [SAMPLE_WIDTH-1:0] out_cube_min_r;
  logic signed [SAMPLE_WIDTH-1:0] out_cube_max_r;
  logic                           out_oor_r;
  logic                           emit_go;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iso_level_r <= '0;
      axis_x_r    <= AXIS_RESET;
      axis_y_r    <= AXIS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ISO_LEVEL: iso_level_r <= cfg_wdata;
        CFG_AXIS_X:    axis_x_r    <= cfg_wdata[AXIS_W-1:0];
        CFG_AXIS_Y:    axis_y_r    <= cfg_wdata[AXIS_W-1:0];
        default:       ;
      endcase
    end
  end

  assign st.query_acc = in_acc && in_kind;
  assign st.far_oor   = (addr_r >= PW'(GRID_DEPTH));
  assign st.out_free  = !out_valid_r || !out_stall;

  // base vertex and plane size latched at query accept
  always_ff @(posedge clk) begin
    if (st.query_acc) begin
      base_r <= PW'(in_vertex_index);
      xy_r   <= XY_W'(axis_x_r) * XY_W'(axis_y_r);
    end
  end

  // corner address adder
  assign a_op = (uw.a_sel == A_BASE) ? base_r : addr_r;

  always_comb begin
    case (uw.b_sel)
      B_X:     b_op = PW'(axis_x_r);
      B_XY:    b_op = PW'(xy_r);
      default: b_op = '0;
    endcase
  end

  assign sum = a_op + b_op + PW'(uw.cin);

  always_ff @(posedge clk) begin
    if (uw.ld_addr) begin
      addr_r <= sum;
    end
  end

  // sample store
  assign wr_en    = in_acc && !in_kind && ({1'b0, in_vertex_index} < (AW + 1)'(GRID_DEPTH));
  assign ram_en   = wr_en || uw.rd;
  assign ram_addr = uw.take ? in_vertex_index : addr_r[AW-1:0];

  icit_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (GRID_DEPTH)
  ) u_ram (
    .clk     (clk),
    .en      (ram_en),
    .we      (wr_en),
    .addr    (ram_addr),
    .wr_data (in_sample_value),
    .rd_data (rd_data)
  );

  // min/max fold
  assign fmin = (uw.fold_init || (rd_data < min_r)) ? rd_data : min_r;
  assign fmax = (uw.fold_init || (rd_data > max_r)) ? rd_data : max_r;

  always_ff @(posedge clk) begin
    if (uw.fold) begin
      min_r <= fmin;
      max_r <= fmax;
    end
  end

  assign iso_ext  = CW'(iso_level_r);
  assign fmin_ext = CW'(fmin);
  assign fmax_ext = CW'(fmax);

  // result word register
  assign emit_go = uw.emit && st.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      if (uw.oor) begin
        out_intersected_r <= 1'b0;
        out_cube_min_r    <= '0;
        out_cube_max_r    <= '0;
        out_oor_r         <= 1'b1;
      end else begin
        out_intersected_r <= (iso_ext >= fmin_ext) && (iso_ext < fmax_ext);
        out_cube_min_r    <= fmin;
        out_cube_max_r    <= fmax;
        out_oor_r         <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_intersected  = out_intersected_r;
  assign out_cube_min     = out_cube_min_r;
  assign out_cube_max     = out_cube_max_r;
  assign out_out_of_range = out_oor_r;

endmodule

`default_nettype wire

// ===== tb/iso_cube_intersection_test_tb.sv =====
// self-checking testbench for iso_cube_intersection_test against a predicted volume
module iso_cube_intersection_test_tb
  import icit_pkg::*;
();

  localparam int DEPTH       = GRID_DEPTH_DEF;
  localparam int SW          = SAMPLE_WIDTH_DEF;
  localparam int VW          = $clog2(DEPTH);
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 9;

  typedef enum {FLOW, COIN, PERIODIC, CHOKE} stall_mode_t;

  typedef struct {
    logic                 hit;
    logic signed [SW-1:0] lo;
    logic signed [SW-1:0] hi;
    logic                 oor;
  } cube_bounds_t;

  class cube_bounds_board;
    logic signed [SW-1:0]    volume [DEPTH];
    logic signed [ISO_W-1:0] iso;
    logic [AXIS_W-1:0]       ax;
    logic [AXIS_W-1:0]       ay;
    cube_bounds_t            pending_bounds [$];
    int                      errors;

    function new();
      foreach (volume[i]) volume[i] = '0;
      iso = '0;
      ax = AXIS_RESET;
      ay = AXIS_RESET;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ISO_W-1:0] d);
      case (idx)
        CFG_ISO_LEVEL: iso = d;
        CFG_AXIS_X:    ax = d[AXIS_W-1:0];
        CFG_AXIS_Y:    ay = d[AXIS_W-1:0];
        default: ;
      endcase
    endfunction

    // offset of cube corner i: bit 0 steps x, bit 1 steps y, bit 2 steps z
    function longint unsigned corner_off(int i);
      longint unsigned x;
      longint unsigned xy;
      x = 64'(ax);
      xy = x * 64'(ay);
      return (i[0] ? 64'd1 : 64'd0) + (i[1] ? x : 64'd0) + (i[2] ? xy : 64'd0);
    endfunction

    function cube_bounds_t predict_cube(logic [VW-1:0] v);
      cube_bounds_t         r;
      logic signed [SW-1:0] s;
      logic [VW-1:0]        a;
      r.hit = 1'b0;
      r.lo = '0;
      r.hi = '0;
      r.oor = 1'b0;
      if (64'(v) + corner_off(7) >= 64'(DEPTH)) begin
        r.oor = 1'b1;
        return r;
      end
      r.lo = volume[v];
      r.hi = r.lo;
      for (int i = 1; i < 8; i++) begin
        a = VW'(64'(v) + corner_off(i));
        s = volume[a];
        if (s < r.lo) r.lo = s;
        if (s > r.hi) r.hi = s;
      end
      r.hit = (iso >= r.lo) && (iso < r.hi);
      return r;
    endfunction

    function void note_word(logic kind, logic [VW-1:0] v, logic [SW-1:0] s);
      if (kind) begin
        pending_bounds.push_back(predict_cube(v));
      end else begin
        volume[v] = s;
      end
    endfunction

    function void check_word(logic hit, logic signed [SW-1:0] lo, logic signed [SW-1:0] hi,
                             logic oor);
      cube_bounds_t e;
      if (pending_bounds.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result word: hit %0b min %0d max %0d oor %0b",
                   hit, lo, hi, oor);
        return;
      end
      e = pending_bounds.pop_front();
      if (hit !== e.hit || lo !== e.lo || hi !== e.hi || oor !== e.oor) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch (hit/min/max/oor): expected %0b/%0d/%0d/%0b, got %0b/%0d/%0d/%0b",
                   e.hit, e.lo, e.hi, e.oor, hit, lo, hi, oor);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [ISO_W-1:0]      cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_kind;
  logic [VW-1:0]         in_vertex_index;
  logic [SW-1:0]         in_sample_value;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_intersected;
  logic signed [SW-1:0]  out_cube_min;
  logic signed [SW-1:0]  out_cube_max;
  logic                  out_out_of_range;

  cube_bounds_board sb = new();
  bit               written [DEPTH];
  int               burst_left = 0;
  int               sent = 0;
  int               cycles = 0;
  logic [VW-1:0]    last_base = '0;
  logic [SW-1:0]    corner_vals [8] = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001,
                                        16'hffff, 16'h0100, 16'h7f00, 16'hff00};

  iso_cube_intersection_test DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_vertex_index  (in_vertex_index),
    .in_sample_value  (in_sample_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_intersected  (out_intersected),
    .out_cube_min     (out_cube_min),
    .out_cube_max     (out_cube_max),
    .out_out_of_range (out_out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (rst_n && out_valid && !out_stall)
      sb.check_word(out_intersected, out_cube_min, out_cube_max, out_out_of_range);
    if (cycles > CYCLE_LIMIT) begin
      $display("iso_cube_intersection_test_tb NOT OK");
      $finish;
    end
  end

  initial begin
    stall_mode_t mode;
    int          len;
    int          per;
    int          duty;
    out_stall = 1'b0;
    forever begin
      mode = stall_mode_t'($urandom_range(3, 0));
      len = $urandom_range(200, 20);
      per = $urandom_range(7, 2);
      duty = $urandom_range(per - 1, 1);
      for (int k = 0; k < len; k++) begin
        @(negedge clk);
        case (mode)
          FLOW:     out_stall <= 1'b0;
          COIN:     out_stall <= 1'($urandom_range(1, 0));
          PERIODIC: out_stall <= (k % per) < duty;
          default:  out_stall <= $urandom_range(3, 0) != 0;
        endcase
      end
    end
  end

  task automatic drive_word(logic k, logic [VW-1:0] v, logic [SW-1:0] s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(4, 0) == 0) ? 60 : $urandom_range(24, 1);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_kind <= k;
    in_vertex_index <= v;
    in_sample_value <= s;
    do @(posedge clk); while (in_stall);
    sb.note_word(k, v, s);
    if (!k) written[v] = 1'b1;
    sent++;
  endtask

  // samples near the iso level hit the min and max boundaries often
  function automatic logic [SW-1:0] pick_sample();
    logic [SW-1:0] i;
    i = sb.iso;
    case ($urandom_range(7, 0))
      0:       return i;
      1:       return i - SW'(1);
      2:       return i + SW'(1);
      3:       return 16'h8000;
      4:       return 16'h7fff;
      5, 6:    return i + SW'($urandom_range(64, 0)) - SW'(32);
      default: return SW'($urandom());
    endcase
  endfunction

  // fresh rewrites all corners, otherwise only corners never written
  task automatic query_cube(logic [VW-1:0] v, bit fresh);
    longint unsigned c;
    if (64'(v) + sb.corner_off(7) < 64'(DEPTH)) begin
      for (int i = 0; i < 8; i++) begin
        c = 64'(v) + sb.corner_off(i);
        if (fresh || !written[c[VW-1:0]]) drive_word(1'b0, c[VW-1:0], pick_sample());
      end
    end
    drive_word(1'b1, v, SW'($urandom()));
    last_base = v;
  endtask

  task automatic random_phase(int n);
    longint m;
    int     stop;
    int     r;
    stop = sent + n;
    while (sent < stop) begin
      m = longint'(DEPTH - 1) - longint'(sb.corner_off(7));
      r = $urandom_range(99, 0);
      if (r < 55 && m >= 0) begin
        if ($urandom_range(3, 0) == 0) query_cube(m[VW-1:0], 1'b1);
        else query_cube(VW'($urandom_range(32'(m), 0)), 1'b1);
      end else if (r < 70) begin
        query_cube(VW'($urandom()), 1'b0);
      end else if (r < 85) begin
        drive_word(1'b0, VW'($urandom()), SW'($urandom()));
      end else if (r < 95) begin
        if (m < 0) query_cube(VW'($urandom()), 1'b0);
        else query_cube(VW'(m + 1 + longint'($urandom_range(32'(DEPTH - 2 - m), 0))), 1'b0);
      end else begin
        query_cube(last_base, 1'b0);
      end
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending_bounds.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [ISO_W-1:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  task automatic set_config(logic [ISO_W-1:0] iso, logic [AXIS_W-1:0] x,
                            logic [AXIS_W-1:0] y);
    settle();
    cfg_write(CFG_ISO_LEVEL, iso);
    cfg_write(CFG_AXIS_X, ISO_W'(x));
    cfg_write(CFG_AXIS_Y, ISO_W'(y));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [ISO_W-1:0]  iso;
    logic [AXIS_W-1:0] x;
    logic [AXIS_W-1:0] y;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_kind = 1'b0;
    in_vertex_index = '0;
    in_sample_value = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // reset configuration: contiguous cube, edge of the store, flat cube, iso on the minimum
    for (int i = 0; i < 8; i++) drive_word(1'b0, VW'(i), corner_vals[i]);
    query_cube('0, 1'b0);
    query_cube(VW'(DEPTH - 7), 1'b0);
    for (int i = 0; i < 8; i++) drive_word(1'b0, VW'(DEPTH - 8 + i), 16'h0005);
    query_cube(VW'(DEPTH - 8), 1'b0);
    drive_word(1'b0, VW'(DEPTH - 6), 16'h0000);
    query_cube(VW'(DEPTH - 8), 1'b0);
    query_cube(VW'(DEPTH - 1), 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       iso = 16'h8000;
        1:       iso = 16'h7fff;
        default: iso = ISO_W'($urandom());
      endcase
      case (p)
        0:       begin x = 2;    y = 2;    end
        1:       begin x = 3;    y = 2;    end
        2:       begin x = 16;   y = 16;   end
        3:       begin x = 0;    y = 0;    end
        4:       begin x = 1;    y = 7;    end
        5:       begin x = 4096; y = 4095; end
        6:       begin x = 60;   y = 60;   end
        default: begin
          x = AXIS_W'($urandom_range(12, 2));
          y = AXIS_W'($urandom_range(12, 2));
        end
      endcase
      set_config(iso, x, y);
      random_phase((p == 5) ? 60 : 110);
    end

    settle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_bounds.size() == 0) begin
      $display("iso_cube_intersection_test_tb OK");
    end else begin
      $display("iso_cube_intersection_test_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== iso_cube_intersection_test.f =====
rtl/icit_pkg.sv
rtl/icit_ram.sv
rtl/icit_useq.sv
rtl/icit_dpath.sv
rtl/iso_cube_intersection_test.sv
tb/iso_cube_intersection_test_tb.sv
